### hw/rtl/lfx_pkg.sv
// Shared types and constants for the LED fader with xenon ignition.
package lfx_pkg;

    localparam int LEVEL_W = 12;
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int DIV_W   = 28;
    localparam int ENTRY_W = 2 * LEVEL_W + 2 * TIME_W;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 12'hFFF;

    localparam logic [CIDX_W-1:0] CFG_FLASH_DURATION = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_RAMP_DURATION  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RAMP_START     = 2'd2;

    typedef struct packed {
        logic [DUR_W-1:0]   flash_dur;
        logic [DUR_W-1:0]   ramp_dur;
        logic [LEVEL_W-1:0] ramp_start;
    } lfx_cfg_t;

    typedef struct packed {
        logic               in_range;
        logic               xenon;
        logic [3:0]         channel;
        logic [TIME_W-1:0]  now;
        logic [LEVEL_W-1:0] tgt;
        logic [LEVEL_W-1:0] fade_tgt;
        logic [DUR_W-1:0]   fade;
        logic [LEVEL_W-1:0] high;
    } lfx_item_t;

endpackage

### hw/rtl/lfx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/lfx_div.sv
// Restoring divider that produces one quotient bit per cycle.
module lfx_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [lfx_pkg::DIV_W-1:0] num,
    input  logic [lfx_pkg::DUR_W-1:0] den,
    output logic                      done,
    output logic [lfx_pkg::DIV_W-1:0] quo
);
    localparam int CNT_W = $clog2(lfx_pkg::DIV_W + 1);

    logic [CNT_W-1:0]            cnt_reg;
    logic [lfx_pkg::DUR_W:0]     rem_reg;
    logic [lfx_pkg::DIV_W-1:0]   shf_reg;
    logic [lfx_pkg::DUR_W-1:0]   den_reg;
    logic                        done_reg;
    logic [lfx_pkg::DUR_W:0]     rem_sh;
    logic                        ge;

    assign rem_sh = {rem_reg[lfx_pkg::DUR_W-1:0], shf_reg[lfx_pkg::DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                cnt_reg  <= CNT_W'(lfx_pkg::DIV_W);
                rem_reg  <= '0;
                shf_reg  <= num;
                den_reg  <= den;
                done_reg <= 1'b0;
            end else if (cnt_reg != '0) begin
                rem_reg  <= ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                shf_reg  <= {shf_reg[lfx_pkg::DIV_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign quo  = shf_reg;
endmodule

### hw/rtl/lfx_front.sv
// Request intake: classifies each request and holds it in a two-entry queue.
module lfx_front #(
    parameter int CHANNELS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [3:0]        s_channel,
    input  logic [31:0]       s_now_ms,
    input  logic [11:0]       s_target,
    input  logic [15:0]       s_fade_time_ms,
    input  logic [11:0]       s_low_level,
    input  logic [11:0]       s_high_level,
    input  logic [2:0]        s_light_request,
    input  logic              s_pass_phase,
    output logic              q_valid,
    input  logic              q_pop,
    output lfx_pkg::lfx_item_t q_head
);
    lfx_pkg::lfx_item_t q_mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    lfx_pkg::lfx_item_t item;
    logic [11:0]        xtgt;
    logic               push;

    always_comb begin
        xtgt = '0;
        if (s_light_request[0]) begin
            xtgt = s_low_level;
        end
        if (s_light_request[1]) begin
            xtgt = s_high_level;
        end
        item.in_range = 32'(s_channel) < CHANNELS;
        item.xenon    = s_cmd;
        item.channel  = s_channel;
        item.now      = s_now_ms;
        item.tgt      = s_cmd ? xtgt : s_target;
        item.fade_tgt = (s_cmd && xtgt != '0 && s_light_request[2] && s_pass_phase)
                        ? s_high_level : item.tgt;
        item.fade     = s_fade_time_ms;
        item.high     = s_high_level;
    end

    assign s_ready = count_reg != 2'd2;
    assign push    = s_valid && s_ready;
    assign q_valid = count_reg != 2'd0;
    assign q_head  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                q_mem_reg[wr_ptr_reg] <= item;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
endmodule

### hw/rtl/lfx_back.sv
// Request execution: per-channel fade and xenon profile update sequencer.
module lfx_back #(
    parameter int CHANNELS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lfx_pkg::lfx_cfg_t  cfg,
    input  logic               q_valid,
    output logic               q_pop,
    input  lfx_pkg::lfx_item_t q_head,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [11:0]        m_level
);
    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DECIDE, S_MUL, S_DIV, S_APPLY, S_WRITE
    } state_t;

    state_t             state_reg;
    lfx_pkg::lfx_item_t item_reg;
    logic [CHANNELS-1:0] vld_reg;
    logic [11:0] fl_reg, xl_reg, res_reg, step_reg, diff_reg, m_level_reg;
    logic [31:0] lt_reg, xs_reg;
    logic [15:0] fe_reg, den_reg;
    logic [27:0] num_reg;
    logic        up_reg, ramp_reg, follow_reg, start_reg, m_valid_reg;

    logic [lfx_pkg::ENTRY_W-1:0] rd_data, wr_data;
    logic        ram_we;
    logic        div_done;
    logic [27:0] div_quo;

    logic        xen_on;
    logic [31:0] xs_eff, elx, fex, elf;
    logic [11:0] st, ftgt, s_eff, app;
    logic [12:0] sum;
    logic        out_free;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign ram_we   = (state_reg == S_WRITE) && out_free && item_reg.in_range;
    assign wr_data  = {fl_reg, lt_reg, follow_reg ? res_reg : xl_reg, xs_reg};

    lfx_ram #(.WIDTH(lfx_pkg::ENTRY_W), .DEPTH(CHANNELS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (IW'(item_reg.channel)),
        .wdata (wr_data),
        .raddr (IW'(q_head.channel)),
        .rdata (rd_data)
    );

    lfx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        st     = cfg.ramp_start;
        xen_on = item_reg.xenon && item_reg.tgt != '0;
        xs_eff = (xl_reg == '0) ? item_reg.now : xs_reg;
        elx    = item_reg.now - xs_eff;
        fex    = elx - 32'(cfg.flash_dur);
        ftgt   = item_reg.fade_tgt;
        elf    = item_reg.now - lt_reg;
        s_eff  = (step_reg == '0) ? 12'd1 : step_reg;
        sum    = {1'b0, fl_reg} + {1'b0, s_eff};
        if (fl_reg < ftgt) begin
            app = (sum > {1'b0, ftgt}) ? ftgt : sum[11:0];
        end else begin
            app = (fl_reg > s_eff) ? fl_reg - s_eff : 12'd0;
            if (app < ftgt) begin
                app = ftgt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            vld_reg     <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && state_reg != S_WRITE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg   <= q_head;
                        follow_reg <= 1'b0;
                        if (q_head.in_range) begin
                            state_reg <= S_READ;
                        end else begin
                            res_reg   <= '0;
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_READ: begin
                    if (vld_reg[IW'(item_reg.channel)]) begin
                        {fl_reg, lt_reg, xl_reg, xs_reg} <= rd_data;
                    end else begin
                        {fl_reg, lt_reg, xl_reg, xs_reg} <= '0;
                    end
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (xen_on && elx <= 32'(cfg.flash_dur)) begin
                        xs_reg    <= xs_eff;
                        xl_reg    <= item_reg.high;
                        res_reg   <= item_reg.high;
                        state_reg <= S_WRITE;
                    end else if (xen_on && elx <= 32'(cfg.ramp_dur)) begin
                        xs_reg <= xs_eff;
                        if (fex[15:0] >= cfg.ramp_dur) begin
                            xl_reg    <= item_reg.tgt;
                            res_reg   <= item_reg.tgt;
                            state_reg <= S_WRITE;
                        end else begin
                            fe_reg    <= fex[15:0];
                            up_reg    <= item_reg.tgt >= st;
                            diff_reg  <= (item_reg.tgt >= st) ? item_reg.tgt - st
                                                              : st - item_reg.tgt;
                            ramp_reg  <= 1'b1;
                            state_reg <= S_MUL;
                        end
                    end else begin
                        ramp_reg <= 1'b0;
                        if (xen_on) begin
                            xs_reg     <= xs_eff;
                            follow_reg <= 1'b1;
                        end else if (item_reg.xenon) begin
                            xl_reg <= '0;
                        end
                        if (fl_reg == ftgt) begin
                            lt_reg    <= item_reg.now;
                            res_reg   <= fl_reg;
                            state_reg <= S_WRITE;
                        end else if (item_reg.fade == '0) begin
                            fl_reg    <= ftgt;
                            res_reg   <= ftgt;
                            state_reg <= S_WRITE;
                        end else if (elf == '0) begin
                            res_reg   <= fl_reg;
                            state_reg <= S_WRITE;
                        end else if (elf >= 32'(item_reg.fade)) begin
                            step_reg  <= lfx_pkg::FULL_SCALE;
                            state_reg <= S_APPLY;
                        end else begin
                            num_reg   <= (28'(elf[15:0]) << 12) - 28'(elf[15:0]);
                            den_reg   <= item_reg.fade;
                            start_reg <= 1'b1;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_MUL: begin
                    num_reg   <= {12'd0, fe_reg} * {16'd0, diff_reg};
                    den_reg   <= cfg.ramp_dur;
                    start_reg <= 1'b1;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    start_reg <= 1'b0;
                    if (div_done) begin
                        if (ramp_reg) begin
                            xl_reg    <= up_reg ? st + div_quo[11:0] : st - div_quo[11:0];
                            res_reg   <= up_reg ? st + div_quo[11:0] : st - div_quo[11:0];
                            state_reg <= S_WRITE;
                        end else begin
                            step_reg  <= div_quo[11:0];
                            state_reg <= S_APPLY;
                        end
                    end
                end
                S_APPLY: begin
                    fl_reg    <= app;
                    lt_reg    <= item_reg.now;
                    res_reg   <= app;
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    if (out_free) begin
                        m_level_reg <= res_reg;
                        m_valid_reg <= 1'b1;
                        if (item_reg.in_range) begin
                            vld_reg[IW'(item_reg.channel)] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> m_valid_reg)
        else $error("state written without a result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE && !item_reg.in_range) |-> !ram_we)
        else $error("out-of-range channel written");
    assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> den_reg != '0)
        else $error("division by zero started");
endmodule

### hw/rtl/led_fader_with_xenon_ignition_unit.sv
// Top level of the per-channel LED fader with xenon ignition profile.
// Requests that need no division bypass the shared 28-step serial divider; the others run
// it before the result is formed.
// One request is executed at a time, and a result stall holds the next one back; a two-entry
// queue decouples intake from execution.
// Synchronous active-low reset restores the register defaults and marks every
// channel's state as zero; no clearing pass is needed.
module led_fader_with_xenon_ignition_unit #(
    parameter int CHANNELS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [3:0]  s_channel,
    input  logic [31:0] s_now_ms,
    input  logic [11:0] s_target,
    input  logic [15:0] s_fade_time_ms,
    input  logic [11:0] s_low_level,
    input  logic [11:0] s_high_level,
    input  logic [2:0]  s_light_request,
    input  logic        s_pass_phase,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_level
);
    lfx_pkg::lfx_cfg_t  cfg_reg;
    lfx_pkg::lfx_item_t q_head;
    logic               q_valid;
    logic               q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flash_dur  <= 16'd30;
            cfg_reg.ramp_dur   <= 16'd8000;
            cfg_reg.ramp_start <= 12'd2048;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lfx_pkg::CFG_FLASH_DURATION: cfg_reg.flash_dur  <= cfg_wdata;
                lfx_pkg::CFG_RAMP_DURATION:  cfg_reg.ramp_dur   <= cfg_wdata;
                lfx_pkg::CFG_RAMP_START:     cfg_reg.ramp_start <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    lfx_front #(.CHANNELS(CHANNELS)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_channel       (s_channel),
        .s_now_ms        (s_now_ms),
        .s_target        (s_target),
        .s_fade_time_ms  (s_fade_time_ms),
        .s_low_level     (s_low_level),
        .s_high_level    (s_high_level),
        .s_light_request (s_light_request),
        .s_pass_phase    (s_pass_phase),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_head          (q_head)
    );

    lfx_back #(.CHANNELS(CHANNELS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_level (m_level)
    );
endmodule
